@@ rtl/lrupr_pkg.sv @@
// Shared types and constants for the LRU page replacement block.
`default_nettype none

package lrupr_pkg;

  // Fixed field widths of the item and result channels
  localparam int PAGE_IN_W   = 16;
  localparam int FRAME_IDX_W = 3;
  localparam int COUNT_W     = 16;
  localparam int CFG_FRAMES_W = 4;

  // Configuration register map (word index taken from paddr[2])
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_FRAMES_IN_USE = 1'b0;
  localparam logic [CFG_FRAMES_W-1:0] FRAMES_RESET = 4'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic look;    // parallel tag compare, pick hit or empty frame
    logic scan;    // examine one frame for the LRU victim
    logic commit;  // write frame state, counters and result
  } lrupr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_scan;  // miss with every active frame full
    logic scan_last;  // current scan frame is the last active one
  } lrupr_sts_t;

endpackage

`default_nettype wire

@@ rtl/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: register port and instances.
// Sequence: the accepting edge loads the reference, the compare state follows, then an
// optional LRU victim scan of one active frame per step, then commit; out_valid is
// registered from commit. busy holds off start from the compare until commit, so a new
// transaction waits for the last. The receiver cannot stall, so results never wait.
// Reset (rst_n low, synchronous): frames invalid, totals zero, frames_in_use = 3.
`default_nettype none

module lru_page_replacement #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Command channel
  input  wire                                  start,
  output logic                                 busy,
  input  wire [lrupr_pkg::PAGE_IN_W-1:0]       in_page_number,
  input  wire                                  in_last_access,
  // Result channel, one-cycle strobe
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [lrupr_pkg::FRAME_IDX_W-1:0]    out_frame_index,
  output logic                                 out_evicted,
  output logic [lrupr_pkg::PAGE_IN_W-1:0]      out_evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]        out_hit_total,
  output logic [lrupr_pkg::COUNT_W-1:0]        out_miss_total,
  // APB register port
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [lrupr_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire [lrupr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lrupr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import lrupr_pkg::*;

  logic [CFG_FRAMES_W-1:0] frames_r;
  logic                    reg_sel;
  lrupr_cmd_t              cmd;
  lrupr_sts_t              sts;

  // Word index is paddr[2]; the low two bits are byte lanes within the word.
  assign reg_sel = (paddr[2] == REG_FRAMES_IN_USE);
  assign pready  = 1'b1;

  // Write on the access phase; writes to other words are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frames_r <= pwdata[CFG_FRAMES_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = APB_DATA_W'(frames_r);
    end
  end

  // Sequencer: load, compare, optional LRU scan, commit
  lrupr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Frame table, ranks and hit/miss totals
  lrupr_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .frames           (frames_r),
    .in_page_number   (in_page_number),
    .in_last_access   (in_last_access),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_frame_index  (out_frame_index),
    .out_evicted      (out_evicted),
    .out_evicted_page (out_evicted_page),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total)
  );

endmodule

`default_nettype wire

@@ rtl/lrupr_ctrl.sv @@
// Sequencing state machine for the LRU page replacement block.
`default_nettype none

module lrupr_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire lrupr_pkg::lrupr_sts_t sts,
  output lrupr_pkg::lrupr_cmd_t  cmd
);
  import lrupr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOK   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        state_nxt = sts.need_scan ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/lrupr_dp.sv @@
// Frame table, recency ranks, counters and result registers.
`default_nettype none

module lrupr_dp #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire lrupr_pkg::lrupr_cmd_t             cmd,
  output lrupr_pkg::lrupr_sts_t                  sts,
  input  wire [lrupr_pkg::CFG_FRAMES_W-1:0]      frames,
  input  wire [lrupr_pkg::PAGE_IN_W-1:0]         in_page_number,
  input  wire                                    in_last_access,
  output logic                                   out_valid,
  output logic                                   out_hit,
  output logic [lrupr_pkg::FRAME_IDX_W-1:0]      out_frame_index,
  output logic                                   out_evicted,
  output logic [lrupr_pkg::PAGE_IN_W-1:0]        out_evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]          out_hit_total,
  output logic [lrupr_pkg::COUNT_W-1:0]          out_miss_total
);
  import lrupr_pkg::*;

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam logic [IW-1:0] RANK_TOP = IW'(MAX_FRAMES - 1);

  // Frame table
  logic [PAGE_BITS-1:0]  page_r  [MAX_FRAMES];
  logic [IW-1:0]         rank_r  [MAX_FRAMES];
  logic [IW-1:0]         rank_nxt[MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r;
  logic [MAX_FRAMES-1:0] valid_nxt;

  // Per-transaction working registers
  logic [PAGE_BITS-1:0]  page_in_r;
  logic                  last_r;
  logic                  hit_r;
  logic                  evict_r;
  logic [IW-1:0]         slot_r;
  logic [IW-1:0]         old_rank_r;
  logic [IW-1:0]         best_r;
  logic [IW-1:0]         scan_idx_r;
  logic [PAGE_BITS-1:0]  vpage_r;

  logic [COUNT_W-1:0]    hits_r;
  logic [COUNT_W-1:0]    hits_nxt;
  logic [COUNT_W-1:0]    misses_r;
  logic [COUNT_W-1:0]    misses_nxt;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [FRAME_IDX_W-1:0] out_frame_index_r;
  logic                  out_evicted_r;
  logic [PAGE_IN_W-1:0]  out_evicted_page_r;
  logic [COUNT_W-1:0]    out_hit_total_r;
  logic [COUNT_W-1:0]    out_miss_total_r;

  logic [CW-1:0]         active;
  logic [MAX_FRAMES-1:0] act_mask;
  logic                  hit_c;
  logic                  empty_c;
  logic [IW-1:0]         hslot_c;
  logic [IW-1:0]         eslot_c;
  logic [IW-1:0]         hrank_c;

  // Clamp frame count to 1..MAX_FRAMES
  always_comb begin
    if (frames == '0) begin
      active = CW'(1);
    end else if (32'(frames) > MAX_FRAMES) begin
      active = CW'(MAX_FRAMES);
    end else begin
      active = CW'(frames);
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      act_mask[i] = (i < int'(active));
    end
  end

  // Parallel compare; walk downward so the lowest index wins
  always_comb begin
    hit_c   = 1'b0;
    empty_c = 1'b0;
    hslot_c = '0;
    eslot_c = '0;
    hrank_c = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (act_mask[i] && valid_r[i] && (page_r[i] == page_in_r)) begin
        hit_c   = 1'b1;
        hslot_c = IW'(i);
        hrank_c = rank_r[i];
      end
      if (act_mask[i] && !valid_r[i]) begin
        empty_c = 1'b1;
        eslot_c = IW'(i);
      end
    end
  end

  assign sts.need_scan = !hit_c && !empty_c;
  assign sts.scan_last = ((32'(scan_idx_r) + 32'd1) == 32'(active));

  // Age frames younger than the touched one (every valid frame on a miss), then make it most recent
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_nxt[i] = rank_r[i];
      if ((IW'(i) != slot_r) && valid_r[i] && (!hit_r || (rank_r[i] < old_rank_r))
          && (rank_r[i] < RANK_TOP)) begin
        rank_nxt[i] = rank_r[i] + 1'b1;
      end
    end
    rank_nxt[slot_r]  = '0;
    valid_nxt[slot_r] = 1'b1;
  end

  assign hits_nxt   = (hit_r && (hits_r != COUNT_MAX)) ? hits_r + 1'b1 : hits_r;
  assign misses_nxt = (!hit_r && (misses_r != COUNT_MAX)) ? misses_r + 1'b1 : misses_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        if (last_r) begin
          // End of run: drop all frames and totals
          valid_r  <= '0;
          hits_r   <= '0;
          misses_r <= '0;
        end else begin
          valid_r  <= valid_nxt;
          hits_r   <= hits_nxt;
          misses_r <= misses_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_in_r <= PAGE_BITS'(in_page_number);
      last_r    <= in_last_access;
    end
    if (cmd.look) begin
      hit_r      <= hit_c;
      evict_r    <= !hit_c && !empty_c;
      slot_r     <= hit_c ? hslot_c : eslot_c;
      old_rank_r <= hrank_c;
      best_r     <= '0;
      scan_idx_r <= '0;
      vpage_r    <= page_r[0];
    end
    if (cmd.scan) begin
      if (rank_r[scan_idx_r] > best_r) begin
        best_r  <= rank_r[scan_idx_r];
        slot_r  <= scan_idx_r;
        vpage_r <= page_r[scan_idx_r];
      end
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (cmd.commit) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (!hit_r) begin
        page_r[slot_r] <= page_in_r;
      end
      out_hit_r          <= hit_r;
      out_frame_index_r  <= FRAME_IDX_W'(slot_r);
      out_evicted_r      <= evict_r;
      out_evicted_page_r <= evict_r ? PAGE_IN_W'(vpage_r) : '0;
      out_hit_total_r    <= hits_nxt;
      out_miss_total_r   <= misses_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame_index  = out_frame_index_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_evicted_page_r;
  assign out_hit_total    = out_hit_total_r;
  assign out_miss_total   = out_miss_total_r;

endmodule

`default_nettype wire

@@ rtl/lrupr_checker.sv @@
// Port-level checks for the LRU page replacement block, bound to the top level.
`default_nettype none

module lrupr_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  wire        busy,
  input  wire        out_valid,
  input  wire        out_hit,
  input  wire        out_evicted,
  input  wire [15:0] out_evicted_page
);

  // An accepted transaction keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Results only follow work, and the strobe lasts one cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !$past(out_valid)))
    else $error("result strobe without preceding work");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted)
    else $error("eviction reported on a hit");

  // Evicted page reads zero when nothing was evicted
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_page == 16'd0))
    else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_hit          (out_hit),
  .out_evicted      (out_evicted),
  .out_evicted_page (out_evicted_page)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 1ps

// One predicted result per page reference
typedef struct packed {
  logic                                hit;
  logic [lrupr_pkg::FRAME_IDX_W-1:0]   frame;
  logic                                evicted;
  logic [lrupr_pkg::PAGE_IN_W-1:0]     evicted_page;
  logic [lrupr_pkg::COUNT_W-1:0]       hit_total;
  logic [lrupr_pkg::COUNT_W-1:0]       miss_total;
} page_outcome_t;

// Tracks the frame table and predicts the outcome of every accepted reference
class lru_outcome_board;
  localparam int NUM_FRAMES  = 8;
  localparam int MAX_REPORTS = 40;

  logic [lrupr_pkg::PAGE_IN_W-1:0]    pages [NUM_FRAMES];
  bit                                 valid [NUM_FRAMES];
  logic [2:0]                         rank  [NUM_FRAMES];
  logic [lrupr_pkg::COUNT_W-1:0]      hits;
  logic [lrupr_pkg::COUNT_W-1:0]      misses;
  logic [lrupr_pkg::CFG_FRAMES_W-1:0] frames_cfg;
  page_outcome_t                      outcome_q [$];
  int                                 errors;
  int                                 reported;

  function new();
    clear_run();
    frames_cfg = lrupr_pkg::FRAMES_RESET;
    errors     = 0;
    reported   = 0;
  endfunction

  function void clear_run();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      pages[i] = '0;
      valid[i] = 1'b0;
      rank[i]  = '0;
    end
    hits   = '0;
    misses = '0;
  endfunction

  function void set_frames(logic [lrupr_pkg::CFG_FRAMES_W-1:0] n);
    frames_cfg = n;
  endfunction

  // Age valid frames younger than old_rank, then make target the newest
  function void promote(int target, int old_rank);
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (i != target && valid[i] && rank[i] < old_rank && rank[i] < NUM_FRAMES - 1)
        rank[i] = rank[i] + 3'd1;
    end
    rank[target] = '0;
  endfunction

  function void note_reference(logic [lrupr_pkg::PAGE_IN_W-1:0] page, logic last);
    int            active;
    int            slot;
    bit            found;
    bit            empty;
    logic [2:0]    best;
    page_outcome_t want;
    active = (frames_cfg == 0) ? 1 : (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg;
    found  = 1'b0;
    empty  = 1'b0;
    slot   = 0;
    want   = '0;
    for (int i = 0; i < active; i++) begin
      if (!found && valid[i] && pages[i] == page) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      promote(slot, rank[slot]);
      if (hits != lrupr_pkg::COUNT_MAX) hits = hits + 1'b1;
    end else begin
      for (int i = 0; i < active; i++) begin
        if (!empty && !valid[i]) begin
          empty = 1'b1;
          slot  = i;
        end
      end
      if (!empty) begin
        // victim is the oldest active frame, lowest index on a tie
        best = '0;
        slot = 0;
        for (int i = 0; i < active; i++) begin
          if (rank[i] > best) begin
            best = rank[i];
            slot = i;
          end
        end
        want.evicted      = 1'b1;
        want.evicted_page = pages[slot];
      end
      pages[slot] = page;
      valid[slot] = 1'b1;
      promote(slot, NUM_FRAMES);
      if (misses != lrupr_pkg::COUNT_MAX) misses = misses + 1'b1;
    end
    want.hit        = found;
    want.frame      = slot[2:0];
    want.hit_total  = hits;
    want.miss_total = misses;
    outcome_q.insert(outcome_q.size(), want);
    if (last) clear_run();
  endfunction

  function void report(string field, longint unsigned want, longint unsigned got);
    errors++;
    if (reported < MAX_REPORTS) begin
      reported++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  function void check_outcome(page_outcome_t got);
    page_outcome_t want;
    if (outcome_q.size() == 0) begin
      errors++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("%0t: result with no reference pending, expected none, actual %h",
                 $time, got);
      end
    end else begin
      want = outcome_q.pop_front();
      if (got.hit !== want.hit) report("hit", want.hit, got.hit);
      if (got.frame !== want.frame) report("frame_index", want.frame, got.frame);
      if (got.evicted !== want.evicted) report("evicted", want.evicted, got.evicted);
      if (got.evicted_page !== want.evicted_page)
        report("evicted_page", want.evicted_page, got.evicted_page);
      if (got.hit_total !== want.hit_total)
        report("hit_total", want.hit_total, got.hit_total);
      if (got.miss_total !== want.miss_total)
        report("miss_total", want.miss_total, got.miss_total);
    end
  endfunction
endclass

module tb;
  // Generous bound: about 400 references plus idle gaps
  localparam int CYCLE_LIMIT = 50_000;
  // Longer than the longest transaction, one with a full victim scan
  localparam int SETTLE = 20;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [lrupr_pkg::PAGE_IN_W-1:0]  in_page_number = '0;
  logic                             in_last_access = 1'b0;
  logic                             psel    = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite  = 1'b0;
  logic [lrupr_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [lrupr_pkg::APB_DATA_W-1:0] pwdata  = '0;

  logic                              busy;
  logic                              out_valid;
  logic                              out_hit;
  logic [lrupr_pkg::FRAME_IDX_W-1:0] out_frame_index;
  logic                              out_evicted;
  logic [lrupr_pkg::PAGE_IN_W-1:0]   out_evicted_page;
  logic [lrupr_pkg::COUNT_W-1:0]     out_hit_total;
  logic [lrupr_pkg::COUNT_W-1:0]     out_miss_total;
  logic [lrupr_pkg::APB_DATA_W-1:0]  prdata;
  logic                              pready;

  lru_outcome_board board = new();
  page_outcome_t    seen;
  int               cycles;

  lru_page_replacement uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .in_last_access   (in_last_access),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_frame_index  (out_frame_index),
    .out_evicted      (out_evicted),
    .out_evicted_page (out_evicted_page),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Observe both channels at every edge. Inputs are driven with nonblocking
  // assignments, so the values read here are the ones the block saw at this edge.
  // Check the result first: it always belongs to an older transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        seen.hit          = out_hit;
        seen.frame        = out_frame_index;
        seen.evicted      = out_evicted;
        seen.evicted_page = out_evicted_page;
        seen.hit_total    = out_hit_total;
        seen.miss_total   = out_miss_total;
        board.check_outcome(seen);
      end
      if (start && !busy) board.note_reference(in_page_number, in_last_access);
    end
  end

  // Watchdog: stop a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** lru_page_replacement: FAILED **");
    $finish;
  end

  // Present one reference and hold it until the block takes it. Leave start
  // high afterwards so a following reference can go out back to back.
  task automatic send_ref(logic [lrupr_pkg::PAGE_IN_W-1:0] page, logic last);
    start          <= 1'b1;
    in_page_number <= page;
    in_last_access <= last;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a gap of n; skip entirely for a zero gap so start stays high
  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every predicted result has arrived
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.outcome_q.size() != 0 || busy);
    repeat (3) @(posedge clk);
  endtask

  // APB write of the frame count: setup phase, then access phase until pready.
  // Fill the unused upper data bits with noise; only the low nibble counts.
  task automatic set_frames(logic [lrupr_pkg::CFG_FRAMES_W-1:0] n);
    logic [lrupr_pkg::APB_DATA_W-1:0] data;
    data = $urandom;
    data[lrupr_pkg::CFG_FRAMES_W-1:0] = n;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lrupr_pkg::REG_FRAMES_IN_USE, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_frames(n);
  endtask

  // Bursts of references drawn mostly from a small page pool so hits, fills
  // and evictions all show up; an occasional fully random page and a rare
  // end-of-run marker mix in.
  task automatic random_refs(int count);
    logic [lrupr_pkg::PAGE_IN_W-1:0] pool [10];
    int pool_size;
    int k;
    int burst;
    int gap;
    logic [lrupr_pkg::PAGE_IN_W-1:0] page;
    for (int i = 0; i < 10; i++) pool[i] = 16'($urandom);
    pool_size = $urandom_range(2, 10);
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 12);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int b = 0; b < burst && k < count; b++) begin
        page = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                            : pool[$urandom_range(0, pool_size - 1)];
        send_ref(page, $urandom_range(0, 39) == 0);
        k++;
      end
      pause(gap);
    end
  endtask

  initial begin
    // Hold reset with every input quiet
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Default three frames: fills, hits, then evictions of the oldest frame
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h8001, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h7FFE, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'hAAAA, 1'b1);
    drain();

    // Zero frames acts as one: the first page fills the single frame, a new page then evicts it
    set_frames(4'd0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h4321, 1'b0);
    drain();

    // Grow to two: the page already in frame 0 still hits
    set_frames(4'd2);
    send_ref(16'h4321, 1'b0);
    send_ref(16'h9999, 1'b0);
    drain();

    // Shrink to one: frame 1 keeps its page while inactive
    set_frames(4'd1);
    send_ref(16'h9999, 1'b0);
    drain();

    // Count above the frame table acts as the full table; the page now sits
    // in two frames and the lower one must win
    set_frames(4'd15);
    send_ref(16'h9999, 1'b0);
    for (int i = 0; i < 7; i++) send_ref(16'h0100 + 16'(i), 1'b0);
    send_ref(16'h0100, 1'b0);
    send_ref(16'h0101, 1'b1);
    drain();

    // Random phases, each at a fresh frame count; runs often span a change
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       set_frames(4'd8);
        1:       set_frames(4'd1);
        2:       set_frames(4'd0);
        3:       set_frames(4'd15);
        default: set_frames(4'($urandom_range(0, 15)));
      endcase
      random_refs(31);
      drain();
    end

    // Let any stray result show up before judging
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.outcome_q.size() == 0) begin
      $display("** lru_page_replacement: PASSED **");
    end else begin
      $display("** lru_page_replacement: FAILED **");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/lrupr_pkg.sv
rtl/lrupr_ctrl.sv
rtl/lrupr_dp.sv
rtl/lru_page_replacement.sv
rtl/lrupr_checker.sv
tb/sv/tb.sv
